// ----- rtl/core/lhm_pkg.sv -----
// ----------------------------------------------------------------------------
// Link handshake monitor package
// Types, codes and helper functions shared by the monitor's files.
// ----------------------------------------------------------------------------
package lhm_pkg;

  // Width of the period and activity timers.
  localparam int unsigned TIMER_W = 16;
  // Width of the period and timeout registers.
  localparam int unsigned PERIOD_W = 16;
  // Width of the configuration write data and register index.
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Rate division: bytes * 1000 needs 32 + 10 bits.
  localparam int unsigned DIVIDEND_W = 42;
  localparam int unsigned DIV_BITS_PER_CYCLE = 2;
  localparam int unsigned DIV_ITER = DIVIDEND_W / DIV_BITS_PER_CYCLE;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_ITER + 1);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MONITOR_ENABLE  = 2'd0,
    CFG_CONNECT_PERIOD  = 2'd1,
    CFG_UPDATE_PERIOD   = 2'd2,
    CFG_CONN_TIMEOUT    = 2'd3
  } lhm_cfg_idx_e;

  localparam logic [PERIOD_W-1:0] CONNECT_PERIOD_RST = 16'd1000;
  localparam logic [PERIOD_W-1:0] UPDATE_PERIOD_RST  = 16'd4000;
  localparam logic [PERIOD_W-1:0] CONN_TIMEOUT_RST   = 16'd8000;

  // Local link state.
  typedef enum logic [1:0] {
    LINK_DISC  = 2'd0,
    LINK_HSREQ = 2'd1,
    LINK_CONN  = 2'd2
  } lhm_link_e;

  // Partner status codes.
  localparam logic [1:0] PARTNER_DISC = 2'd0;
  localparam logic [1:0] PARTNER_ACK  = 2'd2;
  localparam logic [1:0] PARTNER_CONN = 2'd3;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_ACCUM,
    SEQ_DECIDE,
    SEQ_DIV_TX,
    SEQ_DIV_RX,
    SEQ_OUT
  } lhm_seq_e;

  typedef struct packed {
    logic [11:0] rx_bytes;
    logic [11:0] tx_bytes;
    logic [7:0]  rx_errors;
    logic [7:0]  tx_errors;
    logic [7:0]  tx_retry_count;
    logic [7:0]  rx_objects;
    logic [1:0]  partner_status;
    logic        partner_updated;
  } lhm_in_t;

  typedef struct packed {
    logic        report_valid;
    logic [1:0]  link_state;
    logic [31:0] tx_rate;
    logic [31:0] rx_rate;
    logic [31:0] rx_failures_total;
    logic [31:0] tx_failures_total;
    logic [31:0] tx_retries_total;
    logic        force_update;
    logic        connected_event;
    logic        lost_event;
  } lhm_out_t;

  // Request to the divider.
  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [PERIOD_W-1:0]   divisor;
  } lhm_div_req_t;

  // Answer of the divider; quotient is saturated to 32 bits.
  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } lhm_div_rsp_t;

  // Saturating 32-bit accumulate of a count of at most 12 bits.
  function automatic logic [31:0] sat_add32(logic [31:0] a, logic [11:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {21'd0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // x * 1000 as x * 1024 - x * 32 + x * 8.
  function automatic logic [DIVIDEND_W-1:0] mul1000(logic [31:0] x);
    logic [DIVIDEND_W-1:0] xe;
    xe = {{(DIVIDEND_W-32){1'b0}}, x};
    return (xe << 10) - (xe << 5) + (xe << 3);
  endfunction

endpackage

// ----- rtl/core/lhm_if.sv -----
// ----------------------------------------------------------------------------
// Link handshake monitor channels
// Valid/ready channels for the tick items and the result items.
// ----------------------------------------------------------------------------
interface lhm_in_if;
  logic             valid;
  logic             ready;
  lhm_pkg::lhm_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lhm_out_if;
  logic              valid;
  logic              ready;
  lhm_pkg::lhm_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/lhm_div.sv -----
// ----------------------------------------------------------------------------
// Link handshake monitor rate divider
// Restoring divider, two quotient bits per cycle, saturated 32-bit quotient.
// ----------------------------------------------------------------------------
module lhm_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lhm_pkg::lhm_div_req_t req_i,
  output lhm_pkg::lhm_div_rsp_t rsp_o
);

  localparam int unsigned DW = lhm_pkg::DIVIDEND_W;
  localparam int unsigned PW = lhm_pkg::PERIOD_W;

  logic [DW-1:0]                   a_q, a_d;
  logic [PW-1:0]                   r_q, r_d;
  logic [PW-1:0]                   d_q;
  logic [lhm_pkg::DIV_CNT_W-1:0]   cnt_q;
  logic                            done_q;

  // The dividend shifts out at the top while quotient bits shift in below.
  always_comb begin
    logic [DW-1:0] a_t;
    logic [PW-1:0] r_t;
    logic [PW:0]   rs;
    a_t = a_q;
    r_t = r_q;
    for (int i = 0; i < int'(lhm_pkg::DIV_BITS_PER_CYCLE); i++) begin
      rs  = {r_t, a_t[DW-1]};
      a_t = a_t << 1;
      if (rs >= {1'b0, d_q}) begin
        rs     = rs - {1'b0, d_q};
        a_t[0] = 1'b1;
      end
      r_t = rs[PW-1:0];
    end
    a_d = a_t;
    r_d = r_t;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      cnt_q  <= lhm_pkg::DIV_CNT_W'(lhm_pkg::DIV_ITER);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == lhm_pkg::DIV_CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= req_i.dividend;
      r_q <= '0;
      d_q <= req_i.divisor;
    end else if (cnt_q != '0) begin
      a_q <= a_d;
      r_q <= r_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = (|a_q[DW-1:32]) ? 32'hFFFF_FFFF : a_q[31:0];

endmodule

// ----- rtl/core/link_handshake_monitor.sv -----
// ----------------------------------------------------------------------------
// Link handshake monitor
// Per-tick link statistics, periodic and partner-driven reports with byte
// rates, disconnected / handshake / connected states and activity timeout.
// ----------------------------------------------------------------------------
// Steps: an accepted tick is captured, accumulated and decided on; a tick
// with a report then takes two passes of the shared divider (one for the
// transmit rate, one for receive) before its result is offered.
// Flow: one item at a time; the next item is taken once the result has
// been handed on. Reset clears the statistics, the timers and the link
// state and loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module link_handshake_monitor (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [lhm_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [lhm_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  lhm_in_if.sink                               in_i,
  lhm_out_if.source                            out_o
);

  localparam int unsigned TW = lhm_pkg::TIMER_W;
  localparam int unsigned PW = lhm_pkg::PERIOD_W;

  // Configuration registers.
  logic          enable_q;
  logic [PW-1:0] connect_period_q;
  logic [PW-1:0] update_period_q;
  logic [PW-1:0] timeout_q;

  // Sequencer.
  lhm_pkg::lhm_seq_e seq_q, seq_d;

  // Captured tick and result register.
  lhm_pkg::lhm_in_t  in_q;
  lhm_pkg::lhm_out_t out_q;

  // Monitor state.
  lhm_pkg::lhm_link_e link_q, link_d;
  logic [TW-1:0]      period_elapsed_q;
  logic [TW-1:0]      activity_q;
  logic               use_update_q;
  logic [31:0]        per_rx_bytes_q;
  logic [31:0]        per_tx_bytes_q;
  logic [15:0]        per_rx_objects_q;
  logic [31:0]        rx_fail_q;
  logic [31:0]        tx_fail_q;
  logic [31:0]        retry_q;
  logic [PW-1:0]      period_q;

  // Shared divider.
  lhm_pkg::lhm_div_req_t div_req;
  lhm_pkg::lhm_div_rsp_t div_rsp;

  // Controls from the sequencer.
  logic in_ready;
  logic out_valid;
  logic do_accum;
  logic do_decide;
  logic tx_done;
  logic rx_done;

  // Report decision, valid while the sequencer is in its decide step.
  logic [PW-1:0] period_sel;
  logic [PW-1:0] period_eff;
  logic          periodic;
  logic          partner_trig;
  logic          report;
  logic [TW-1:0] activity_new;
  logic          timeout;
  logic          force_upd;
  logic          conn_ev;
  logic          lost_ev;

  // --------------------------------------------------------------------------
  // Configuration port. Write only while idle (the block does not enforce it).
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q         <= 1'b0;
      connect_period_q <= lhm_pkg::CONNECT_PERIOD_RST;
      update_period_q  <= lhm_pkg::UPDATE_PERIOD_RST;
      timeout_q        <= lhm_pkg::CONN_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (lhm_pkg::lhm_cfg_idx_e'(cfg_idx_i))
        lhm_pkg::CFG_MONITOR_ENABLE: enable_q         <= cfg_data_i[0];
        lhm_pkg::CFG_CONNECT_PERIOD: connect_period_q <= cfg_data_i[PW-1:0];
        lhm_pkg::CFG_UPDATE_PERIOD:  update_period_q  <= cfg_data_i[PW-1:0];
        lhm_pkg::CFG_CONN_TIMEOUT:   timeout_q        <= cfg_data_i[PW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: capture the tick, accumulate, decide, run the divider twice on
  // a report, then hold the result until the sink takes it.
  // --------------------------------------------------------------------------
  always_comb begin
    seq_d = seq_q;
    unique case (seq_q)
      lhm_pkg::SEQ_IDLE:   if (in_i.valid) seq_d = lhm_pkg::SEQ_ACCUM;
      lhm_pkg::SEQ_ACCUM:  seq_d = lhm_pkg::SEQ_DECIDE;
      lhm_pkg::SEQ_DECIDE: seq_d = report ? lhm_pkg::SEQ_DIV_TX : lhm_pkg::SEQ_OUT;
      lhm_pkg::SEQ_DIV_TX: if (div_rsp.done) seq_d = lhm_pkg::SEQ_DIV_RX;
      lhm_pkg::SEQ_DIV_RX: if (div_rsp.done) seq_d = lhm_pkg::SEQ_OUT;
      lhm_pkg::SEQ_OUT:    if (out_o.ready) seq_d = lhm_pkg::SEQ_IDLE;
      default:             seq_d = lhm_pkg::SEQ_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (seq_q == lhm_pkg::SEQ_IDLE);
    out_valid = (seq_q == lhm_pkg::SEQ_OUT);
    do_accum  = (seq_q == lhm_pkg::SEQ_ACCUM);
    do_decide = (seq_q == lhm_pkg::SEQ_DECIDE);
    tx_done   = (seq_q == lhm_pkg::SEQ_DIV_TX) && div_rsp.done;
    rx_done   = (seq_q == lhm_pkg::SEQ_DIV_RX) && div_rsp.done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= lhm_pkg::SEQ_IDLE;
    end else begin
      seq_q <= seq_d;
    end
  end

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_q;

  // --------------------------------------------------------------------------
  // Report decision. The period in use is taken before any switch, and a
  // period register holding zero behaves as a period of one.
  // --------------------------------------------------------------------------
  always_comb begin
    period_sel   = use_update_q ? update_period_q : connect_period_q;
    period_eff   = (period_sel == '0) ? PW'(1) : period_sel;
    periodic     = enable_q &&
                   ({{(32-TW){1'b0}}, period_elapsed_q} >= {{(32-PW){1'b0}}, period_eff});
    partner_trig = in_q.partner_updated &&
                   ((link_q != lhm_pkg::LINK_CONN) ||
                    (in_q.partner_status != lhm_pkg::PARTNER_CONN));
    report       = periodic || partner_trig;

    // Objects seen during the period restart the activity timer first.
    activity_new = (per_rx_objects_q != '0) ? '0 : activity_q;
    timeout      = {{(32-TW){1'b0}}, activity_new} > {{(32-PW){1'b0}}, timeout_q};

    link_d = link_q;
    unique case (link_q)
      lhm_pkg::LINK_DISC:  link_d = lhm_pkg::LINK_HSREQ;
      lhm_pkg::LINK_HSREQ: begin
        if (in_q.partner_status == lhm_pkg::PARTNER_ACK) link_d = lhm_pkg::LINK_CONN;
      end
      lhm_pkg::LINK_CONN: begin
        if ((in_q.partner_status == lhm_pkg::PARTNER_DISC) || timeout) begin
          link_d = lhm_pkg::LINK_DISC;
        end
      end
      default: link_d = link_q;
    endcase

    force_upd = (link_d != lhm_pkg::LINK_CONN) ||
                (in_q.partner_status != lhm_pkg::PARTNER_CONN);
    conn_ev   = (link_d == lhm_pkg::LINK_CONN) && (link_q != lhm_pkg::LINK_CONN);
    lost_ev   = (link_d == lhm_pkg::LINK_DISC) && (link_q != lhm_pkg::LINK_DISC);
  end

  // --------------------------------------------------------------------------
  // Divider requests: the transmit rate starts from the decide step, the
  // receive rate as soon as the transmit rate is done.
  // --------------------------------------------------------------------------
  always_comb begin
    div_req.start    = (do_decide && report) || tx_done;
    div_req.dividend = lhm_pkg::mul1000(do_decide ? per_tx_bytes_q : per_rx_bytes_q);
    div_req.divisor  = do_decide ? period_eff : period_q;
  end

  lhm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // --------------------------------------------------------------------------
  // Statistics, timers and link state.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q           <= lhm_pkg::LINK_DISC;
      period_elapsed_q <= '0;
      activity_q       <= '0;
      use_update_q     <= 1'b0;
      per_rx_bytes_q   <= '0;
      per_tx_bytes_q   <= '0;
      per_rx_objects_q <= '0;
      rx_fail_q        <= '0;
      tx_fail_q        <= '0;
      retry_q          <= '0;
    end else if (do_accum) begin
      per_rx_bytes_q <= lhm_pkg::sat_add32(per_rx_bytes_q, in_q.rx_bytes);
      per_tx_bytes_q <= lhm_pkg::sat_add32(per_tx_bytes_q, in_q.tx_bytes);
      rx_fail_q      <= lhm_pkg::sat_add32(rx_fail_q, {4'd0, in_q.rx_errors});
      tx_fail_q      <= lhm_pkg::sat_add32(tx_fail_q, {4'd0, in_q.tx_errors});
      retry_q        <= lhm_pkg::sat_add32(retry_q, {4'd0, in_q.tx_retry_count});
      if ({1'b0, per_rx_objects_q} + {9'd0, in_q.rx_objects} > 17'h0FFFF) begin
        per_rx_objects_q <= 16'hFFFF;
      end else begin
        per_rx_objects_q <= per_rx_objects_q + {8'd0, in_q.rx_objects};
      end
      if (period_elapsed_q != '1) period_elapsed_q <= period_elapsed_q + 1'b1;
      if (activity_q != '1) activity_q <= activity_q + 1'b1;
    end else if (do_decide && report) begin
      if (periodic) period_elapsed_q <= '0;
      activity_q <= activity_new;
      link_q     <= link_d;
      if (conn_ev) use_update_q <= 1'b1;
      if (lost_ev) use_update_q <= 1'b0;
    end else if (rx_done) begin
      // Both rates are out of the divider; start a fresh period.
      per_rx_bytes_q   <= '0;
      per_tx_bytes_q   <= '0;
      per_rx_objects_q <= '0;
    end
  end

  // --------------------------------------------------------------------------
  // Captured tick, rate period and result register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      in_q <= in_i.data;
    end
    if (do_decide) begin
      period_q                <= period_eff;
      out_q.report_valid      <= report;
      out_q.link_state        <= report ? link_d : link_q;
      out_q.tx_rate           <= '0;
      out_q.rx_rate           <= '0;
      out_q.rx_failures_total <= rx_fail_q;
      out_q.tx_failures_total <= tx_fail_q;
      out_q.tx_retries_total  <= retry_q;
      out_q.force_update      <= report && force_upd;
      out_q.connected_event   <= report && conn_ev;
      out_q.lost_event        <= report && lost_ev;
    end
    if (tx_done) out_q.tx_rate <= div_rsp.quotient;
    if (rx_done) out_q.rx_rate <= div_rsp.quotient;
  end

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// Link handshake monitor testbench
// Drives millisecond ticks into the monitor through its valid/ready channels
// and checks every result against a cycle-free model of the tick statistics,
// the periodic and partner-triggered reports, the byte rates and the
// disconnected / handshake / connected machine. Register settings change
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  import lhm_pkg::*;

  localparam int unsigned MS_PER_SECOND = 1000;
  // Cycles with no accepted item or taken result before the run is declared
  // hung. This is many times the longest quiet stretch that a report, a
  // receiver stall and a sender pause can make together.
  localparam int unsigned HANG_LIMIT = 2000;
  // Random items before and after the long accumulation window.
  localparam int unsigned RANDOM_ITEMS = 780;
  // Ticks in the long window; enough near-full receive counts to push the
  // receive rate over 32 bits at a one millisecond period.
  localparam int unsigned LONG_WINDOW = 1070;

  // Model of the monitor: it keeps its own copy of the registers and the
  // statistics state, predicts one result per accepted tick and compares the
  // results that come out of the block in order.
  class link_stats_scoreboard;
    bit          mon_en;
    logic [15:0] connect_per;
    logic [15:0] update_per;
    logic [15:0] conn_tmo;
    lhm_link_e   link;
    logic [15:0] period_age;
    logic [15:0] activity_age;
    bit          on_update_per;
    logic [31:0] win_rx_bytes;
    logic [31:0] win_tx_bytes;
    logic [15:0] win_objects;
    logic [31:0] rx_err_total;
    logic [31:0] tx_err_total;
    logic [31:0] retry_total;
    lhm_out_t    pending[$];
    int unsigned failures;
    int unsigned ticks;
    int unsigned reports;
    int unsigned connects;
    int unsigned losses;
    int unsigned timeouts;
    int unsigned saturated;

    function new();
      mon_en        = 1'b0;
      connect_per   = CONNECT_PERIOD_RST;
      update_per    = UPDATE_PERIOD_RST;
      conn_tmo      = CONN_TIMEOUT_RST;
      link          = LINK_DISC;
      period_age    = '0;
      activity_age  = '0;
      on_update_per = 1'b0;
      win_rx_bytes  = '0;
      win_tx_bytes  = '0;
      win_objects   = '0;
      rx_err_total  = '0;
      tx_err_total  = '0;
      retry_total   = '0;
      failures      = 0;
      ticks         = 0;
      reports       = 0;
      connects      = 0;
      losses        = 0;
      timeouts      = 0;
      saturated     = 0;
    endfunction

    function logic [31:0] capped_sum(logic [31:0] a, logic [31:0] b, logic [31:0] cap);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, cap}) ? cap : s[31:0];
    endfunction

    function logic [31:0] byte_rate(logic [31:0] bytes, logic [15:0] per);
      longint unsigned q;
      q = ({32'd0, bytes} * 64'(MS_PER_SECOND)) / {48'd0, per};
      if (q > 64'hFFFF_FFFF) begin
        saturated++;
        return 32'hFFFF_FFFF;
      end
      return q[31:0];
    endfunction

    // Only the register's own width of the write data counts.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (lhm_cfg_idx_e'(idx))
        CFG_MONITOR_ENABLE: mon_en = val[0];
        CFG_CONNECT_PERIOD: connect_per = val;
        CFG_UPDATE_PERIOD:  update_per = val;
        CFG_CONN_TIMEOUT:   conn_tmo = val;
        default: ;
      endcase
    endfunction

    function void note_tick(lhm_in_t t);
      lhm_out_t    r;
      logic [15:0] per;
      bit          periodic;
      bit          by_partner;
      bit          timed_out;
      lhm_link_e   prev;
      r = '0;
      ticks++;
      // The tick's counts land first; the report decision sees them.
      win_rx_bytes = capped_sum(win_rx_bytes, 32'(t.rx_bytes), 32'hFFFF_FFFF);
      win_tx_bytes = capped_sum(win_tx_bytes, 32'(t.tx_bytes), 32'hFFFF_FFFF);
      win_objects  = 16'(capped_sum(32'(win_objects), 32'(t.rx_objects), 32'h0000_FFFF));
      rx_err_total = capped_sum(rx_err_total, 32'(t.rx_errors), 32'hFFFF_FFFF);
      tx_err_total = capped_sum(tx_err_total, 32'(t.tx_errors), 32'hFFFF_FFFF);
      retry_total  = capped_sum(retry_total, 32'(t.tx_retry_count), 32'hFFFF_FFFF);
      period_age   = 16'(capped_sum(32'(period_age), 32'd1, 32'h0000_FFFF));
      activity_age = 16'(capped_sum(32'(activity_age), 32'd1, 32'h0000_FFFF));

      per = on_update_per ? update_per : connect_per;
      if (per == '0) per = 16'd1;
      periodic   = mon_en && (period_age >= per);
      by_partner = t.partner_updated &&
                   (link != LINK_CONN || t.partner_status != PARTNER_CONN);

      if (periodic || by_partner) begin
        prev = link;
        reports++;
        r.report_valid = 1'b1;
        // A report caused only by the partner leaves the period timer running.
        if (periodic) period_age = '0;
        r.tx_rate = byte_rate(win_tx_bytes, per);
        r.rx_rate = byte_rate(win_rx_bytes, per);
        if (win_objects != '0) activity_age = '0;
        timed_out = activity_age > conn_tmo;
        case (link)
          LINK_DISC: link = LINK_HSREQ;
          LINK_HSREQ: begin
            if (t.partner_status == PARTNER_ACK) link = LINK_CONN;
          end
          LINK_CONN: begin
            if (t.partner_status == PARTNER_DISC || timed_out) begin
              if (t.partner_status != PARTNER_DISC) timeouts++;
              link = LINK_DISC;
            end
          end
          default: ;
        endcase
        r.force_update = (link != LINK_CONN) || (t.partner_status != PARTNER_CONN);
        if (link == LINK_CONN && prev != LINK_CONN) begin
          on_update_per     = 1'b1;
          r.connected_event = 1'b1;
          connects++;
        end
        if (link == LINK_DISC && prev != LINK_DISC) begin
          on_update_per = 1'b0;
          r.lost_event  = 1'b1;
          losses++;
        end
        win_rx_bytes = '0;
        win_tx_bytes = '0;
        win_objects  = '0;
      end

      r.link_state        = link;
      r.rx_failures_total = rx_err_total;
      r.tx_failures_total = tx_err_total;
      r.tx_retries_total  = retry_total;
      pending.insert(pending.size(), r);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        failures++;
        $error("%s: expected %0d, got %0d", name, want, got);
      end
    endfunction

    function void check_result(lhm_out_t got);
      lhm_out_t want;
      if (pending.size() == 0) begin
        failures++;
        $error("result arrived with no tick waiting for one");
        return;
      end
      want = pending[0];
      pending.delete(0);
      check_field("report_valid", 32'(want.report_valid), 32'(got.report_valid));
      check_field("link_state", 32'(want.link_state), 32'(got.link_state));
      check_field("tx_rate", want.tx_rate, got.tx_rate);
      check_field("rx_rate", want.rx_rate, got.rx_rate);
      check_field("rx_failures_total", want.rx_failures_total, got.rx_failures_total);
      check_field("tx_failures_total", want.tx_failures_total, got.tx_failures_total);
      check_field("tx_retries_total", want.tx_retries_total, got.tx_retries_total);
      check_field("force_update", 32'(want.force_update), 32'(got.force_update));
      check_field("connected_event", 32'(want.connected_event),
                  32'(got.connected_event));
      check_field("lost_event", 32'(want.lost_event), 32'(got.lost_event));
    endfunction

    function void check_drained();
      if (pending.size() != 0) begin
        failures += unsigned'(pending.size());
        $error("%0d ticks never produced a result", pending.size());
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  lhm_in_if  in_ch();
  lhm_out_if out_ch();

  link_handshake_monitor dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  link_stats_scoreboard sb;

  // Sender burst bookkeeping: items left in the current burst.
  int unsigned burst_left;
  // Receiver pattern: cycles left before the ready level flips again.
  int unsigned ready_hold = 0;

  always #5 clk = ~clk;

  // Everything is sampled at the rising edge, while all stimulus moves at the
  // falling edge, so the values seen here are stable for the whole cycle.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.write_reg(cfg_idx, cfg_data);
      if (in_ch.valid && in_ch.ready) sb.note_tick(in_ch.data);
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
    end
  end

  // The receiver alternates runs of ready with stalls. Most stalls are short,
  // some last long enough to hold a finished result back, and now and then a
  // long ready run lets results stream out with no back-pressure at all.
  always @(negedge clk) begin
    if (ready_hold != 0) begin
      ready_hold--;
    end else if (out_ch.ready) begin
      out_ch.ready <= 1'b0;
      ready_hold = ($urandom_range(0, 9) == 9) ? $urandom_range(20, 25) :
                   ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) :
                   $urandom_range(0, 3);
    end else begin
      out_ch.ready <= 1'b1;
      ready_hold = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) :
                   $urandom_range(1, 40);
    end
  end

  // A run that stops accepting items for too long is hung.
  initial begin : hang_guard
    int unsigned quiet;
    quiet = 0;
    while (quiet < HANG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Mostly uniform values, with a fair share of zero and all-ones so the
  // extremes of every field show up often.
  function automatic int unsigned pick(int unsigned top);
    case ($urandom_range(0, 7))
      0: return 0;
      1: return top;
      default: return $urandom_range(0, top);
    endcase
  endfunction

  function automatic lhm_in_t make_tick(logic [11:0] rxb, logic [11:0] txb,
                                        logic [7:0] rxe, logic [7:0] txe,
                                        logic [7:0] rtr, logic [7:0] rxo,
                                        logic [1:0] status, logic upd);
    lhm_in_t t;
    t.rx_bytes        = rxb;
    t.tx_bytes        = txb;
    t.rx_errors       = rxe;
    t.tx_errors       = txe;
    t.tx_retry_count  = rtr;
    t.rx_objects      = rxo;
    t.partner_status  = status;
    t.partner_updated = upd;
    return t;
  endfunction

  // Random tick. A well-formed tick plays the partner's side of the handshake
  // from the state the model says the link is in: while not connected it
  // mostly answers with request or ack updates, once connected it mostly
  // reports connected and only now and then drops the link. Noise ticks pick
  // the partner fields with no regard to the state. With rare objects the
  // activity timer is left to run out, which is how timeouts happen.
  function automatic lhm_in_t random_tick(bit noisy, bit objects_rare);
    lhm_in_t     t;
    int unsigned roll;
    t.rx_bytes       = 12'(pick(4095));
    t.tx_bytes       = 12'(pick(4095));
    t.rx_errors      = 8'(pick(255));
    t.tx_errors      = 8'(pick(255));
    t.tx_retry_count = 8'(pick(255));
    if (objects_rare) t.rx_objects = ($urandom_range(0, 15) == 0) ? 8'(pick(255)) : 8'd0;
    else t.rx_objects = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'(pick(255));
    roll = $urandom_range(0, 9);
    if (noisy) begin
      t.partner_status  = 2'($urandom_range(0, 3));
      t.partner_updated = 1'($urandom_range(0, 1));
    end else if (sb.link == LINK_CONN) begin
      t.partner_updated = ($urandom_range(0, 3) == 0);
      t.partner_status  = (roll < 8) ? PARTNER_CONN :
                          (roll == 8) ? PARTNER_DISC : 2'($urandom_range(1, 2));
    end else begin
      t.partner_updated = (roll < 6);
      t.partner_status  = ($urandom_range(0, 1) == 0) ? PARTNER_ACK :
                          2'($urandom_range(0, 3));
    end
    return t;
  endfunction

  // Offers one item and returns once it has been taken. Valid stays high into
  // the next item while a burst lasts; at the end of a burst it drops for a
  // gap before the next burst starts.
  task automatic send_tick(input lhm_in_t t);
    in_ch.valid <= 1'b1;
    in_ch.data  <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    if (burst_left != 0) burst_left--;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat (($urandom_range(0, 4) == 0) ? $urandom_range(10, 16) : $urandom_range(1, 6))
        @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150) :
                   $urandom_range(1, 20);
    end
  endtask

  // Holds the sender back until every tick has produced its result and the
  // block is surely idle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input lhm_cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
  endtask

  // Writes all four registers back to back. The upper bits of the enable
  // word are random since only bit zero belongs to the register.
  task automatic set_config(input bit en, input logic [15:0] cper,
                            input logic [15:0] uper, input logic [15:0] tmo);
    logic [CFG_DATA_W-1:0] en_word;
    en_word    = CFG_DATA_W'($urandom());
    en_word[0] = en;
    cfg_write(CFG_MONITOR_ENABLE, en_word);
    cfg_write(CFG_CONNECT_PERIOD, cper);
    cfg_write(CFG_UPDATE_PERIOD, uper);
    cfg_write(CFG_CONN_TIMEOUT, tmo);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] random_period();
    case ($urandom_range(0, 9))
      0: return 16'd1;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(1, 24));
    endcase
  endfunction

  // One phase: fresh register values, then a run of random ticks. Most
  // periods are short so periodic reports come often; a period of one reports
  // every tick, and the largest leaves only partner updates to cause reports.
  task automatic random_phase(inout int unsigned sent);
    int unsigned len;
    bit          rare;
    logic [15:0] tmo;
    case ($urandom_range(0, 9))
      0: tmo = 16'd1;
      1: tmo = 16'd65534;
      default: tmo = 16'($urandom_range(2, 40));
    endcase
    drain();
    set_config($urandom_range(0, 6) != 0, random_period(), random_period(), tmo);
    len  = $urandom_range(40, 110);
    rare = ($urandom_range(0, 2) == 0);
    repeat (len) send_tick(random_tick($urandom_range(0, 4) == 0, rare));
    sent += len;
  endtask

  initial begin
    int unsigned sent;
    lhm_in_t     t;
    sb            = new();
    sent          = 0;
    burst_left    = $urandom_range(1, 20);
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.data    = '0;
    out_ch.ready  = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Register defaults, reports only by partner update: a quiet tick, a
    // full tick that starts the handshake, the ack that connects, a connected
    // update that causes nothing, a request while connected that still
    // forces a report, and a disconnect.
    send_tick(make_tick(12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 8'd0, PARTNER_DISC, 1'b0));
    send_tick(make_tick(12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 2'd1, 1'b1));
    send_tick(make_tick(12'd0, 12'hFFF, 8'd1, 8'd0, 8'd3, 8'd0, PARTNER_ACK, 1'b1));
    send_tick(make_tick(12'd7, 12'd9, 8'd0, 8'd0, 8'd0, 8'd1, PARTNER_CONN, 1'b1));
    send_tick(make_tick(12'd100, 12'd0, 8'd0, 8'd2, 8'd0, 8'd0, 2'd1, 1'b1));
    send_tick(make_tick(12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 8'd0, PARTNER_DISC, 1'b1));

    // A connect period written as zero behaves as one, so every tick reports.
    // Connected with a one tick timeout: objects keep the link up, two quiet
    // ticks lose it, and an ack brings the handshake back.
    drain();
    set_config(1'b1, 16'd0, 16'd1, 16'd1);
    send_tick(make_tick(12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 8'd0, PARTNER_DISC, 1'b0));
    send_tick(make_tick(12'hFFF, 12'hFFF, 8'd0, 8'd0, 8'd0, 8'd0, PARTNER_ACK, 1'b0));
    send_tick(make_tick(12'd1, 12'd2, 8'd0, 8'd0, 8'd0, 8'hFF, PARTNER_CONN, 1'b0));
    send_tick(make_tick(12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 8'd0, PARTNER_CONN, 1'b0));
    send_tick(make_tick(12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 8'd0, PARTNER_CONN, 1'b0));
    send_tick(make_tick(12'd5, 12'd5, 8'd0, 8'd0, 8'd0, 8'd0, PARTNER_ACK, 1'b1));

    // Largest periods and timeout: no periodic report is ever due here.
    drain();
    set_config(1'b1, 16'hFFFF, 16'hFFFF, 16'd65534);
    send_tick(make_tick(12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 8'd0, PARTNER_DISC, 1'b0));
    send_tick(make_tick(12'hFFF, 12'd1, 8'd0, 8'd0, 8'd0, 8'd4, PARTNER_ACK, 1'b1));
    send_tick(make_tick(12'd3, 12'd3, 8'd0, 8'd0, 8'd0, 8'd0, PARTNER_CONN, 1'b1));
    send_tick(make_tick(12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 8'd0, PARTNER_DISC, 1'b1));
    send_tick(make_tick(12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, PARTNER_CONN, 1'b1));

    while (sent < RANDOM_ITEMS / 2) random_phase(sent);

    // Long window with no report at all, then one partner update at a one
    // millisecond period: the receive rate goes past 32 bits and saturates,
    // and the object counter of the window saturates on the way.
    drain();
    set_config(1'b0, 16'd1, 16'd1, 16'($urandom_range(1, 65534)));
    repeat (LONG_WINDOW) begin
      t                 = random_tick(1'b1, 1'b0);
      t.rx_bytes        = 12'($urandom_range(4064, 4095));
      t.partner_updated = 1'b0;
      send_tick(t);
    end
    t                 = random_tick(1'b1, 1'b0);
    t.partner_status  = 2'd1;
    t.partner_updated = 1'b1;
    send_tick(t);

    while (sent < RANDOM_ITEMS) random_phase(sent);

    drain();
    repeat (60) @(posedge clk);
    sb.check_drained();
    $display("Ran %0d ticks with %0d reports under changing periods and timeouts.",
             sb.ticks, sb.reports);
    $display("Saw %0d connects, %0d losses (%0d by timeout), %0d saturated rates.",
             sb.connects, sb.losses, sb.timeouts, sb.saturated);
    if (sb.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
